### hdl/dge_pkg.sv
// Shared types and register codes for the decimal digit glyph emitter.
`default_nettype none

package dge_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_PITCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_ENABLE = 2'd3;

    localparam logic [3:0] SIGN_GLYPH = 4'd10;

    localparam int SRC_X_W  = 14;
    localparam int DEST_X_W = 17;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic start;
        logic shift;
        logic scan_step;
        logic load_sign;
        logic load_digit;
    } dge_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic scan_done;
        logic idx_zero;
        logic out_free;
        logic sign_en;
    } dge_status_t;

endpackage

`default_nettype wire

### hdl/dge_ctrl.sv
// Sequencer: conversion, leading-zero scan and glyph emission.
`default_nettype none

module dge_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire dge_pkg::dge_status_t status,
    output dge_pkg::dge_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.conv_last)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = status.sign_en ? ST_SIGN : ST_DIGITS;
                else
                    cmd.scan_step = 1'b1;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.load_sign = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (status.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    if (status.idx_zero)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

### hdl/dge_datapath.sv
// Serial double-dabble converter, config registers and output word register.
`default_nettype none

module dge_datapath #(
    parameter int MAX_DIGITS = 10,
    parameter int VALUE_BITS = 31
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [dge_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [dge_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [VALUE_BITS-1:0]               value,
    input  wire dge_pkg::dge_cmd_t                   cmd,
    output dge_pkg::dge_status_t                     status,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [dge_pkg::SRC_X_W-1:0]              src_x,
    output logic [dge_pkg::DEST_X_W-1:0]             dest_x,
    output logic                                     is_sign,
    output logic                                     last
);

    // enough decimal digits to hold any VALUE_BITS number
    localparam int BCD_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int IDX_W      = $clog2(BCD_DIGITS);
    localparam int IDX_START  = (BCD_DIGITS < MAX_DIGITS ? BCD_DIGITS : MAX_DIGITS) - 1;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    localparam int SW = dge_pkg::SRC_X_W;
    localparam int DW = dge_pkg::DEST_X_W;

    logic [9:0]  glyph_width_reg;
    logic [9:0]  glyph_pitch_reg;
    logic [15:0] start_x_reg;
    logic        sign_enable_reg;

    logic [VALUE_BITS-1:0]        bin_reg;
    logic [BCD_DIGITS-1:0][3:0]   bcd_reg;
    logic [BCD_DIGITS-1:0][3:0]   bcd_adj;
    logic [BCD_DIGITS-1:0][3:0]   bcd_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [DW-1:0]                acc_reg;

    logic                         out_valid_reg;
    logic [SW-1:0]                src_x_reg;
    logic [DW-1:0]                dest_x_reg;
    logic                         is_sign_reg;
    logic                         last_reg;

    logic [3:0]                   cur_digit;
    logic                         high_nz;
    logic [DW-1:0]                start_ext;
    logic [DW-1:0]                pitch_ext;
    logic [SW-1:0]                digit_src;
    logic [SW-1:0]                sign_src;

    // add-3 correction, then shift left one bit with the next binary MSB
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            bcd_adj[d] = (bcd_reg[d] >= 4'd5) ? bcd_reg[d] + 4'd3 : bcd_reg[d];
        end
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (d == 0)
                bcd_next[d] = {bcd_adj[d][2:0], bin_reg[VALUE_BITS-1]};
            else
                bcd_next[d] = {bcd_adj[d][2:0], bcd_adj[d-1][3]};
        end
    end

    // nonzero digits beyond the emitted window force leading zeros to be kept
    always_comb
    begin
        high_nz = 1'b0;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (d >= MAX_DIGITS)
                high_nz = high_nz | (bcd_reg[d] != 4'd0);
        end
    end

    assign cur_digit = bcd_reg[idx_reg];
    assign start_ext = {start_x_reg[15], start_x_reg};
    assign pitch_ext = {{(DW-10){1'b0}}, glyph_pitch_reg};
    assign digit_src = {{(SW-4){1'b0}}, cur_digit} * {{(SW-10){1'b0}}, glyph_width_reg};
    assign sign_src  = {{(SW-4){1'b0}}, dge_pkg::SIGN_GLYPH}
                     * {{(SW-10){1'b0}}, glyph_width_reg};

    always_comb
    begin
        status.conv_last = (cnt_reg == CNT_W'(1));
        status.idx_zero  = (idx_reg == '0);
        status.scan_done = high_nz || (cur_digit != 4'd0) || (idx_reg == '0);
        status.out_free  = !out_valid_reg || out_ready;
        status.sign_en   = sign_enable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg <= 10'd16;
            glyph_pitch_reg <= 10'd16;
            start_x_reg     <= 16'd0;
            sign_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dge_pkg::REG_GLYPH_WIDTH: glyph_width_reg <= cfg_data[9:0];
                dge_pkg::REG_GLYPH_PITCH: glyph_pitch_reg <= cfg_data[9:0];
                dge_pkg::REG_START_X:     start_x_reg     <= cfg_data;
                dge_pkg::REG_SIGN_ENABLE: sign_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_sign || cmd.load_digit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
            cnt_reg <= CNT_W'(VALUE_BITS);
            idx_reg <= IDX_W'(IDX_START);
            acc_reg <= start_ext + pitch_ext;
        end
        if (cmd.shift)
        begin
            bcd_reg <= bcd_next;
            bin_reg <= {bin_reg[VALUE_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.scan_step)
            idx_reg <= idx_reg - IDX_W'(1);
        if (cmd.load_sign)
        begin
            src_x_reg   <= sign_src;
            dest_x_reg  <= start_ext;
            is_sign_reg <= 1'b1;
            last_reg    <= 1'b0;
        end
        if (cmd.load_digit)
        begin
            src_x_reg   <= digit_src;
            dest_x_reg  <= acc_reg;
            is_sign_reg <= 1'b0;
            last_reg    <= (idx_reg == '0);
            acc_reg     <= acc_reg + pitch_ext;
            idx_reg     <= idx_reg - IDX_W'(1);
        end
    end

    assign out_valid = out_valid_reg;
    assign src_x     = src_x_reg;
    assign dest_x    = dest_x_reg;
    assign is_sign   = is_sign_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

### hdl/decimal_digit_glyph_emitter.sv
// Top level: splits a binary number into decimal digit glyph positions.
// Per number: accept, serial double-dabble conversion, leading-zero scan, then one word
// per cycle while the output is not stalled (sign glyph first if enabled); the next
// number is accepted once the final word sits in the output register.
// Reset (rst_n low, async): idle, m_tvalid low, width/pitch 16, start_x 0, sign off.
`default_nettype none

module decimal_digit_glyph_emitter #(
    parameter int MAX_DIGITS = 10,
    parameter int VALUE_BITS = 31
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [dge_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dge_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: value, zero padded
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: src_x[13:0], dest_x[30:14], zero pad[31]
    output logic [dge_pkg::OUT_DATA_W-1:0]         m_tdata,
    // m_tuser: is_sign
    output logic                                   m_tuser,
    output logic                                   m_tlast
);

    dge_pkg::dge_cmd_t    cmd;
    dge_pkg::dge_status_t status;

    logic [dge_pkg::SRC_X_W-1:0]  src_x;
    logic [dge_pkg::DEST_X_W-1:0] dest_x;

    dge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dge_datapath #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .src_x     (src_x),
        .dest_x    (dest_x),
        .is_sign   (m_tuser),
        .last      (m_tlast)
    );

    assign m_tdata = {1'b0, dest_x, src_x};

endmodule

`default_nettype wire

### tb/decimal_digit_glyph_emitter_tb.sv
// Testbench for the decimal digit glyph emitter: stream stimulus, predicted glyphs, checks.
`timescale 1ns / 1ps

module decimal_digit_glyph_emitter_tb;

    localparam int MAX_DIGITS   = 10;
    localparam int VALUE_BITS   = 31;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 60;

    typedef struct packed {
        logic [dge_pkg::SRC_X_W-1:0]  src_x;
        logic [dge_pkg::DEST_X_W-1:0] dest_x;
        logic                         is_sign;
        logic                         last;
    } glyph_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [dge_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dge_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [31:0]                    s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dge_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    decimal_digit_glyph_emitter #(
        .MAX_DIGITS(MAX_DIGITS),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the registers
    logic [9:0]  width_reg = 10'd16;
    logic [9:0]  pitch_reg = 10'd16;
    logic [15:0] start_x_reg = 16'd0;
    logic        sign_reg = 1'b0;

    logic [30:0] value_q[$];
    glyph_t      glyph_q[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_request = 1'b0;
    logic rx_hold = 1'b0;

    int errors = 0;
    int numbers_in = 0;
    int glyphs_out = 0;
    int sign_glyphs = 0;
    int settings_used = 1;
    int quiet = 0;

    function automatic void predict_glyphs(input logic [30:0] value);
        logic [3:0]  digits [0:MAX_DIGITS-1];
        logic [30:0] v;
        int          n;
        int          x0;
        int          src_full;
        int          dest_full;
        glyph_t      g;
        v = value;
        n = 0;
        do
        begin
            digits[n] = 4'(v % 31'd10);
            n++;
            v = v / 31'd10;
        end
        while (v != 0 && n < MAX_DIGITS);
        x0 = int'($signed(start_x_reg));
        if (sign_reg)
        begin
            src_full = int'(dge_pkg::SIGN_GLYPH) * int'(width_reg);
            g.src_x = src_full[dge_pkg::SRC_X_W-1:0];
            g.dest_x = x0[dge_pkg::DEST_X_W-1:0];
            g.is_sign = 1'b1;
            g.last = 1'b0;
            glyph_q.push_back(g);
        end
        for (int i = 0; i < n; i++)
        begin
            src_full = int'(digits[n-1-i]) * int'(width_reg);
            dest_full = x0 + (i + 1) * int'(pitch_reg);
            g.src_x = src_full[dge_pkg::SRC_X_W-1:0];
            g.dest_x = dest_full[dge_pkg::DEST_X_W-1:0];
            g.is_sign = 1'b0;
            g.last = (i == n - 1);
            glyph_q.push_back(g);
        end
    endfunction

    // mostly spread over digit counts, sometimes raw 31-bit patterns
    function automatic logic [30:0] random_value();
        longint lo;
        longint hi;
        int     ndig;
        if ($urandom_range(9) < 3)
            return 31'($urandom);
        ndig = $urandom_range(1, 10);
        lo = (ndig == 1) ? 0 : 1;
        for (int i = 1; i < ndig; i++)
            lo = lo * 10;
        hi = (ndig == 10) ? 64'd2147483647 : lo * 10 - 1;
        if (ndig == 1)
            hi = 9;
        return 31'(lo + longint'($urandom) % (hi - lo + 1));
    endfunction

    task automatic write_reg(input logic [dge_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            dge_pkg::REG_GLYPH_WIDTH: width_reg = data[9:0];
            dge_pkg::REG_GLYPH_PITCH: pitch_reg = data[9:0];
            dge_pkg::REG_START_X:     start_x_reg = data;
            dge_pkg::REG_SIGN_ENABLE: sign_reg = data[0];
            default: ;
        endcase
    endtask

    // upper data bits beyond a register's width carry noise
    task automatic set_config(input logic [9:0] w, input logic [9:0] p,
                              input logic [15:0] sx, input logic sg);
        write_reg(dge_pkg::REG_GLYPH_WIDTH, {6'($urandom), w});
        write_reg(dge_pkg::REG_GLYPH_PITCH, {6'($urandom), p});
        write_reg(dge_pkg::REG_START_X, sx);
        write_reg(dge_pkg::REG_SIGN_ENABLE, {15'($urandom), sg});
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (value_q.size() != 0 || s_tvalid || glyph_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            value_q.push_back(random_value());
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (value_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, value_q.pop_front()};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver stall so the block backs up into its input
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // monitor: check outgoing glyphs, then predict from accepted numbers
    always @(posedge clk)
    begin
        glyph_t got;
        glyph_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.src_x = m_tdata[13:0];
                got.dest_x = m_tdata[30:14];
                got.is_sign = m_tuser;
                got.last = m_tlast;
                glyphs_out++;
                if (got.is_sign)
                    sign_glyphs++;
                if (glyph_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: src_x=%0d dest_x=%0d sign=%0b last=%0b",
                                 got.src_x, $signed(got.dest_x), got.is_sign, got.last);
                end
                else
                begin
                    want = glyph_q.pop_front();
                    if (got.src_x !== want.src_x || got.dest_x !== want.dest_x ||
                        got.is_sign !== want.is_sign || got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: exp src_x=%0d dest_x=%0d sign=%0b last=%0b",
                                     want.src_x, $signed(want.dest_x), want.is_sign,
                                     want.last);
                            $display("          got src_x=%0d dest_x=%0d sign=%0b last=%0b",
                                     got.src_x, $signed(got.dest_x), got.is_sign,
                                     got.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                numbers_in++;
                predict_glyphs(s_tdata[30:0]);
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        tx_idle_pct = 9;
        rx_idle_pct = 73;
        // reset settings, directed values
        value_q.push_back(31'd0);
        value_q.push_back(31'd1);
        value_q.push_back(31'd9);
        value_q.push_back(31'd10);
        value_q.push_back(31'd99);
        value_q.push_back(31'd100);
        value_q.push_back(31'd101);
        value_q.push_back(31'd999999999);
        value_q.push_back(31'd1000000000);
        value_q.push_back(31'd1234567890);
        value_q.push_back(31'd2147483647);
        value_q.push_back(31'h55555555);
        value_q.push_back(31'h2AAAAAAA);
        value_q.push_back(31'h40000000);
        value_q.push_back(31'd1000000007);
        value_q.push_back(31'd9876543);
        wait_drained();

        // wide glyphs, widest pitch, rightmost start, sign on
        set_config(10'd1023, 10'd1023, 16'h7FFF, 1'b1);
        value_q.push_back(31'd0);
        value_q.push_back(31'd2147483647);
        value_q.push_back(31'd1999999999);
        push_random(30);
        wait_drained();

        tx_idle_pct = 73;
        rx_idle_pct = 9;
        // narrowest nonzero glyph, zero pitch, leftmost start
        set_config(10'd1, 10'd0, 16'h8000, 1'b1);
        push_random(30);
        wait_drained();

        // zero glyph width gives src_x of zero throughout
        set_config(10'd0, 10'd1, 16'hFFFF, 1'b0);
        push_random(30);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(10'($urandom_range(1, 1023)), 10'($urandom_range(0, 1023)),
                   16'($urandom), 1'($urandom_range(1)));
        hold_request = 1'b1;
        push_random(30);
        wait_drained();

        set_config(10'($urandom_range(1, 1023)), 10'($urandom_range(0, 1023)),
                   16'($urandom), 1'($urandom_range(1)));
        push_random(30);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (glyph_q.size() != 0)
        begin
            errors += glyph_q.size();
            $display("%0d expected glyphs never arrived", glyph_q.size());
        end

        $display("covered %0d numbers and %0d glyphs (%0d sign) over %0d register settings",
                 numbers_in, glyphs_out, sign_glyphs, settings_used);
        $display("idle mixes on both sides plus one long output stall; %0d mismatches", errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### decimal_digit_glyph_emitter.f
hdl/dge_pkg.sv
hdl/dge_ctrl.sv
hdl/dge_datapath.sv
hdl/decimal_digit_glyph_emitter.sv
tb/decimal_digit_glyph_emitter_tb.sv
